[design/cubic_bezier_sampler_macros.svh]
// Assertion macros used by the checker of the Bezier sampler.
`ifndef CUBIC_BEZIER_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CBS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/cbs_pkg.sv]
// Types and constants shared by the Bezier sampler modules.
`default_nettype none
package cbs_pkg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIVB_INIT,
        OP_DIV_STEP,
        OP_DIVB_DONE,
        OP_MUL,
        OP_NINIT,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIVN_INIT,
        OP_DIVN_DONE,
        OP_OUT_LOAD
    } cbs_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVB_INIT,
        ST_DIVB,
        ST_DIVB_DONE,
        ST_MUL,
        ST_NINIT,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIVN_INIT,
        ST_DIVN,
        ST_DIVN_DONE,
        ST_OUT
    } cbs_state_t;

    typedef struct packed {
        cbs_op_t    op;
        logic [5:0] cnt;
        logic [1:0] comp;
    } cbs_cmd_t;

    typedef struct packed {
        logic shift_done;
        logic out_free;
        logic last;
    } cbs_stat_t;

    // Sequence lengths (last count value of each loop)
    localparam logic [5:0] DIV_LAST  = 6'd44;
    localparam logic [5:0] MUL_LAST  = 6'd47;
    localparam logic [5:0] SQ_LAST   = 6'd3;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [1:0] COMP_LAST = 2'd2;

    // Multiply schedule: weight chain steps
    localparam logic [5:0] STEP_AA = 6'd0;
    localparam logic [5:0] STEP_AB = 6'd1;
    localparam logic [5:0] STEP_BB = 6'd2;
    localparam logic [5:0] STEP_W0 = 6'd3;
    localparam logic [5:0] STEP_W1 = 6'd4;
    localparam logic [5:0] STEP_W2 = 6'd5;
    localparam logic [5:0] STEP_W3 = 6'd6;
    localparam logic [1:0] REGION_POS = 2'd1;
    localparam logic [1:0] REGION_G   = 2'd2;
    localparam logic [1:0] LANE_NONE  = 2'd3;

    localparam logic [1:0] IDX_START   = 2'd3;
    localparam logic [5:0] STEPS_RESET = 6'd16;
    localparam logic [16:0] Q16_ONE    = 17'd65536;

endpackage
`default_nettype wire

[design/cbs_datapath.sv]
// Datapath of the Bezier sampler: points, shared multiplier, divider, root, output register.
`default_nettype none
module cbs_datapath
    import cbs_pkg::*;
#(
    parameter int MAX_STEPS   = 63,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cbs_cmd_t                      cmd,
    output cbs_stat_t                          stat,
    input  wire logic                          cfg_wr_en,
    input  wire logic [5:0]                    cfg_wr_data,
    input  wire logic [1:0]                    s_point_index,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [5:0]                         m_sample_index,
    output logic signed [COORD_WIDTH-1:0]      m_pos_x,
    output logic signed [COORD_WIDTH-1:0]      m_pos_y,
    output logic signed [COORD_WIDTH-1:0]      m_pos_z,
    output logic signed [15:0]                 m_norm_x,
    output logic signed [15:0]                 m_norm_y,
    output logic signed [15:0]                 m_norm_z,
    output logic                               m_degenerate,
    output logic                               m_last_sample
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int AW = CW + 27;
    localparam int MA = 35;
    localparam int MB = 31;
    localparam int MP = MA + MB;

    typedef enum logic [3:0] {
        TAG_NONE, TAG_AA, TAG_AB, TAG_BB, TAG_W0, TAG_W1, TAG_W2, TAG_W3,
        TAG_POS, TAG_G, TAG_SQ
    } tag_t;

    logic [5:0]           steps_reg, n_reg, i_reg, n_clamp;
    logic signed [CW-1:0] cp_reg [0:11];
    logic [16:0]          b_reg, a_val;
    logic [33:0]          aa_reg, ab_reg, bb_reg;
    logic [24:0]          w_reg [0:3];
    logic [24:0]          q_val [0:2];
    logic [34:0]          q_sum [0:2];
    logic signed [AW-1:0] pos_acc [0:2];
    logic signed [AW-1:0] g_acc [0:2];
    logic [AW-1:0]        mag_reg [0:2];
    logic [2:0]           neg_reg;
    logic                 degen_reg;
    logic [63:0]          sq_reg, sx_reg, sr_reg, sq_bit, sq_try;
    logic [4:0]           sm_reg;
    logic [44:0]          num_reg;
    logic [30:0]          rem_reg, dsr_reg;
    logic [31:0]          div_rs;
    logic                 div_ge;
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MP-1:0] prod_reg;
    tag_t                 tag_next, tag_reg;
    logic [1:0]           lane_next, lane_reg;
    logic [1:0]           sel_j, sel_c;
    logic [3:0]           idx0, idx1;
    logic signed [CW-1:0] coord0, coord1;
    logic signed [DW-1:0] diff;
    logic [49:0]          p_lo;
    logic [51:0]          p_one, p_three;
    logic [AW-1:0]        mag_sel;
    logic                 neg_sel;
    logic [15:0]          q_out, n_val;
    logic signed [AW-1:0] pos_rnd [0:2];
    logic signed [AW-1:0] pos_shr [0:2];
    logic [CW-1:0]        pos_sat [0:2];
    logic                 m_valid_reg, m_degen_reg, m_last_reg;
    logic [5:0]           m_idx_reg;
    logic [CW-1:0]        m_pos_reg [0:2];
    logic [15:0]          m_nrm_reg [0:2];
    logic [15:0]          nrm_reg [0:2];

    // Clamp the interval count for a new run
    always_comb begin
        if (steps_reg == 6'd0) begin
            n_clamp = 6'd1;
        end else if (steps_reg > 6'(MAX_STEPS)) begin
            n_clamp = 6'(MAX_STEPS);
        end else begin
            n_clamp = steps_reg;
        end
    end

    assign a_val = Q16_ONE - b_reg;

    // Rounded quadratic weights
    assign q_sum[0] = 35'(aa_reg) + 35'd128;
    assign q_sum[1] = 35'({ab_reg, 1'b0}) + 35'd128;
    assign q_sum[2] = 35'(bb_reg) + 35'd128;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_val[k] = q_sum[k][32:8];
        end
    end

    // Pick coordinates for the current multiply step
    assign sel_j = cmd.cnt[1:0];
    assign sel_c = cmd.cnt[3:2];
    assign idx0  = (sel_c == LANE_NONE || sel_j == 2'd3) ?
                   ((sel_c == LANE_NONE) ? 4'd0 : 4'(sel_j) * 4'd3 + 4'(sel_c)) :
                   4'(sel_j) * 4'd3 + 4'(sel_c);
    assign idx1  = (sel_c == LANE_NONE || sel_j == 2'd3) ? 4'd0 : idx0 + 4'd3;
    assign coord0 = cp_reg[idx0];
    assign coord1 = cp_reg[idx1];
    assign diff   = DW'(coord0) - DW'(coord1);

    // Select multiplier operands and the destination of the product
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        tag_next  = TAG_NONE;
        lane_next = sel_c;
        if (cmd.op == OP_MUL) begin
            case (cmd.cnt)
                STEP_AA: begin
                    mul_a = MA'(a_val); mul_b = MB'(a_val); tag_next = TAG_AA;
                end
                STEP_AB: begin
                    mul_a = MA'(a_val); mul_b = MB'(b_reg); tag_next = TAG_AB;
                end
                STEP_BB: begin
                    mul_a = MA'(b_reg); mul_b = MB'(b_reg); tag_next = TAG_BB;
                end
                STEP_W0: begin
                    mul_a = MA'(aa_reg); mul_b = MB'(a_val); tag_next = TAG_W0;
                end
                STEP_W1: begin
                    mul_a = MA'(aa_reg); mul_b = MB'(b_reg); tag_next = TAG_W1;
                end
                STEP_W2: begin
                    mul_a = MA'(ab_reg); mul_b = MB'(b_reg); tag_next = TAG_W2;
                end
                STEP_W3: begin
                    mul_a = MA'(bb_reg); mul_b = MB'(b_reg); tag_next = TAG_W3;
                end
                default: begin
                    if (cmd.cnt[5:4] == REGION_POS && sel_c != LANE_NONE) begin
                        mul_a    = MA'(coord0);
                        mul_b    = MB'(w_reg[sel_j]);
                        tag_next = TAG_POS;
                    end else if (cmd.cnt[5:4] == REGION_G && sel_c != LANE_NONE
                                 && sel_j != 2'd3) begin
                        mul_a    = MA'(diff);
                        mul_b    = MB'(q_val[sel_j]);
                        tag_next = TAG_G;
                    end
                end
            endcase
        end else if (cmd.op == OP_SQ && cmd.cnt[1:0] != 2'd3) begin
            mul_a    = MA'(mag_reg[cmd.cnt[1:0]][29:0]);
            mul_b    = MB'(mag_reg[cmd.cnt[1:0]][29:0]);
            tag_next = TAG_SQ;
        end
    end

    // Weight rounding from the registered product
    assign p_lo    = prod_reg[49:0];
    assign p_one   = 52'(p_lo) + 52'd8388608;
    assign p_three = 52'(p_lo) + 52'({p_lo, 1'b0}) + 52'd8388608;

    // Divider and root step terms
    assign div_rs = {rem_reg, num_reg[44]};
    assign div_ge = (div_rs >= {1'b0, dsr_reg});
    assign sq_bit = 64'd1 << {sm_reg, 1'b0};
    assign sq_try = sr_reg + sq_bit;

    // Normal component chosen for division
    always_comb begin
        case (cmd.comp)
            2'd0:    begin mag_sel = mag_reg[0]; neg_sel = neg_reg[0]; end
            2'd1:    begin mag_sel = mag_reg[1]; neg_sel = neg_reg[1]; end
            default: begin mag_sel = mag_reg[2]; neg_sel = neg_reg[2]; end
        endcase
        q_out = num_reg[15:0];
        if (degen_reg) begin
            n_val = '0;
        end else if (neg_sel) begin
            n_val = 16'(-q_out);
        end else begin
            n_val = q_out;
        end
    end

    // Round and saturate positions
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos_rnd[k] = pos_acc[k] + AW'(24'h800000);
            pos_shr[k] = pos_rnd[k] >>> 24;
            if (pos_shr[k][AW-1:CW-1] == '0 || pos_shr[k][AW-1:CW-1] == '1) begin
                pos_sat[k] = pos_shr[k][CW-1:0];
            end else begin
                pos_sat[k] = {pos_shr[k][AW-1], {(CW-1){~pos_shr[k][AW-1]}}};
            end
        end
    end

    // Control state: configuration, points, run counters, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg   <= STEPS_RESET;
            n_reg       <= 6'd1;
            i_reg       <= '0;
            m_valid_reg <= 1'b0;
            tag_reg     <= TAG_NONE;
            for (int k = 0; k < 12; k++) begin
                cp_reg[k] <= '0;
            end
        end else begin
            tag_reg <= tag_next;
            if (cfg_wr_en) begin
                steps_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_LOAD) begin
                for (int k = 0; k < 4; k++) begin
                    if (s_point_index == 2'(k)) begin
                        cp_reg[k*3]     <= s_point_x;
                        cp_reg[k*3 + 1] <= s_point_y;
                        cp_reg[k*3 + 2] <= s_point_z;
                    end
                end
                if (s_point_index == IDX_START) begin
                    n_reg <= n_clamp;
                    i_reg <= '0;
                end
            end
            if (cmd.op == OP_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
                if (i_reg != n_reg) begin
                    i_reg <= i_reg + 6'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        lane_reg <= lane_next;

        // write back the previous product
        case (tag_reg)
            TAG_AA: aa_reg   <= prod_reg[33:0];
            TAG_AB: ab_reg   <= prod_reg[33:0];
            TAG_BB: bb_reg   <= prod_reg[33:0];
            TAG_W0: w_reg[0] <= p_one[48:24];
            TAG_W1: w_reg[1] <= p_three[48:24];
            TAG_W2: w_reg[2] <= p_three[48:24];
            TAG_W3: w_reg[3] <= p_one[48:24];
            TAG_POS: begin
                for (int k = 0; k < 3; k++) begin
                    if (lane_reg == 2'(k)) begin
                        pos_acc[k] <= pos_acc[k] + signed'(prod_reg[AW-1:0]);
                    end
                end
            end
            TAG_G: begin
                for (int k = 0; k < 3; k++) begin
                    if (lane_reg == 2'(k)) begin
                        g_acc[k] <= g_acc[k] + signed'(prod_reg[AW-1:0]);
                    end
                end
            end
            TAG_SQ: sq_reg <= sq_reg + 64'(prod_reg[59:0]);
            default: ;
        endcase

        case (cmd.op)
            OP_DIVB_INIT: begin
                num_reg <= 45'({i_reg, 16'b0}) + 45'(n_reg >> 1);
                dsr_reg <= 31'(n_reg);
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? 31'(div_rs - {1'b0, dsr_reg}) : div_rs[30:0];
                num_reg <= {num_reg[43:0], div_ge};
            end
            OP_DIVB_DONE: b_reg <= num_reg[16:0];
            OP_MUL: begin
                if (cmd.cnt == STEP_AA) begin
                    for (int k = 0; k < 3; k++) begin
                        pos_acc[k] <= '0;
                        g_acc[k]   <= '0;
                    end
                end
            end
            OP_NINIT: begin
                // normal direction is (gy, -gx, -gz)
                mag_reg[0] <= g_acc[1][AW-1] ? AW'(-g_acc[1]) : AW'(g_acc[1]);
                mag_reg[1] <= g_acc[0][AW-1] ? AW'(-g_acc[0]) : AW'(g_acc[0]);
                mag_reg[2] <= g_acc[2][AW-1] ? AW'(-g_acc[2]) : AW'(g_acc[2]);
                neg_reg[0] <= g_acc[1][AW-1];
                neg_reg[1] <= !g_acc[0][AW-1] && (g_acc[0] != '0);
                neg_reg[2] <= !g_acc[2][AW-1] && (g_acc[2] != '0);
                degen_reg  <= (g_acc[0] == '0) && (g_acc[1] == '0) && (g_acc[2] == '0);
                sq_reg     <= '0;
            end
            OP_SHIFT: begin
                if (!stat.shift_done) begin
                    for (int k = 0; k < 3; k++) begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end
            end
            OP_SQRT_INIT: begin
                sx_reg <= sq_reg;
                sr_reg <= '0;
                sm_reg <= 5'd31;
            end
            OP_SQRT_STEP: begin
                if (sx_reg >= sq_try) begin
                    sx_reg <= sx_reg - sq_try;
                    sr_reg <= (sr_reg >> 1) + sq_bit;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sm_reg <= sm_reg - 5'd1;
            end
            OP_DIVN_INIT: begin
                num_reg <= {1'b0, mag_sel[29:0], 14'b0} + 45'(sr_reg[30:1]);
                dsr_reg <= sr_reg[30:0];
                rem_reg <= '0;
            end
            OP_DIVN_DONE: begin
                for (int k = 0; k < 3; k++) begin
                    if (cmd.comp == 2'(k)) begin
                        nrm_reg[k] <= n_val;
                    end
                end
            end
            OP_OUT_LOAD: begin
                m_idx_reg   <= i_reg;
                m_degen_reg <= degen_reg;
                m_last_reg  <= (i_reg == n_reg);
                for (int k = 0; k < 3; k++) begin
                    m_pos_reg[k] <= pos_sat[k];
                    m_nrm_reg[k] <= nrm_reg[k];
                end
            end
            default: ;
        endcase
    end

    assign stat.shift_done = (mag_reg[0][AW-1:30] == '0) && (mag_reg[1][AW-1:30] == '0)
                             && (mag_reg[2][AW-1:30] == '0);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.last       = (i_reg == n_reg);

    assign m_valid        = m_valid_reg;
    assign m_sample_index = m_idx_reg;
    assign m_pos_x        = m_pos_reg[0];
    assign m_pos_y        = m_pos_reg[1];
    assign m_pos_z        = m_pos_reg[2];
    assign m_norm_x       = m_nrm_reg[0];
    assign m_norm_y       = m_nrm_reg[1];
    assign m_norm_z       = m_nrm_reg[2];
    assign m_degenerate   = m_degen_reg;
    assign m_last_sample  = m_last_reg;

endmodule
`default_nettype wire

[design/cbs_controller.sv]
// Sequencer of the Bezier sampler: steps the datapath through each sample.
`default_nettype none
module cbs_controller
    import cbs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_point_index,
    input  wire cbs_stat_t  stat,
    output cbs_cmd_t        cmd
);

    cbs_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        comp_next  = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid && s_point_index == IDX_START) begin
                    state_next = ST_DIVB_INIT;
                end
            end
            ST_DIVB_INIT: begin
                cnt_next   = '0;
                state_next = ST_DIVB;
            end
            ST_DIVB: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DIVB_DONE;
                end
            end
            ST_DIVB_DONE: begin
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_NINIT;
                end
            end
            ST_NINIT: state_next = ST_SHIFT;
            ST_SHIFT: begin
                cnt_next = '0;
                if (stat.shift_done) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (cnt_reg == SQ_LAST) begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT: begin
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                comp_next = '0;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_DIVN_INIT;
                end
            end
            ST_DIVN_INIT: begin
                cnt_next   = '0;
                state_next = ST_DIVN;
            end
            ST_DIVN: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DIVN_DONE;
                end
            end
            ST_DIVN_DONE: begin
                if (comp_reg == COMP_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DIVN_INIT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.last ? ST_IDLE : ST_DIVB_INIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: datapath command and input ready
    always_comb begin
        s_ready  = 1'b0;
        cmd.op   = OP_NONE;
        cmd.cnt  = cnt_reg;
        cmd.comp = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_DIVB_INIT: cmd.op = OP_DIVB_INIT;
            ST_DIVB:      cmd.op = OP_DIV_STEP;
            ST_DIVB_DONE: cmd.op = OP_DIVB_DONE;
            ST_MUL:       cmd.op = OP_MUL;
            ST_NINIT:     cmd.op = OP_NINIT;
            ST_SHIFT:     cmd.op = OP_SHIFT;
            ST_SQ:        cmd.op = OP_SQ;
            ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            ST_SQRT:      cmd.op = OP_SQRT_STEP;
            ST_DIVN_INIT: cmd.op = OP_DIVN_INIT;
            ST_DIVN:      cmd.op = OP_DIV_STEP;
            ST_DIVN_DONE: cmd.op = OP_DIVN_DONE;
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.op = OP_OUT_LOAD;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

[design/cubic_bezier_sampler.sv]
// Top level of the cubic Bezier sampler with unit normals.
//
//   channel  direction  handshake        contents
//   s_       in         s_valid/s_ready  point_index, point_x/y/z (Q8.16)
//   m_       out        m_valid/m_ready  sample_index, pos, norm, flags
//   cfg_     in         cfg_wr_en        steps (6 bits)
//
// Points 0..2 are stored; point 3 starts a run of steps+1 samples (steps 0 as 1).
// Each sample runs a 45-step serial divider for the parameter, 48 slots of the shared
// multiplier, a shift that scales the normal down until it fits, 32 root steps and
// the 45-step divider again for each of the three normal components.
// Reset is synchronous and active low; points clear to zero, steps to 16.
// A stalled result holds the sequencer until the output register frees up.
`default_nettype none
module cubic_bezier_sampler
    import cbs_pkg::*;
#(
    parameter int MAX_STEPS   = 63,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [5:0]                    cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_point_index,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [5:0]                         m_sample_index,
    output logic signed [COORD_WIDTH-1:0]      m_pos_x,
    output logic signed [COORD_WIDTH-1:0]      m_pos_y,
    output logic signed [COORD_WIDTH-1:0]      m_pos_z,
    output logic signed [15:0]                 m_norm_x,
    output logic signed [15:0]                 m_norm_y,
    output logic signed [15:0]                 m_norm_z,
    output logic                               m_degenerate,
    output logic                               m_last_sample
);

    cbs_cmd_t  cmd;
    cbs_stat_t stat;

    // Sequencer
    cbs_controller u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_index (s_point_index),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Arithmetic and storage
    cbs_datapath #(
        .MAX_STEPS   (MAX_STEPS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_point_index  (s_point_index),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_point_z      (s_point_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_index (m_sample_index),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_pos_z        (m_pos_z),
        .m_norm_x       (m_norm_x),
        .m_norm_y       (m_norm_y),
        .m_norm_z       (m_norm_z),
        .m_degenerate   (m_degenerate),
        .m_last_sample  (m_last_sample)
    );

endmodule
`default_nettype wire

[design/cbs_checker.sv]
// Port-level checks of the Bezier sampler and their binding to the top level.
`default_nettype none
`include "cubic_bezier_sampler_macros.svh"
module cbs_checker #(
    parameter int COORD_WIDTH = 24
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [5:0]                    m_sample_index,
    input wire logic signed [COORD_WIDTH-1:0] m_pos_x,
    input wire logic signed [15:0]            m_norm_x,
    input wire logic signed [15:0]            m_norm_y,
    input wire logic signed [15:0]            m_norm_z,
    input wire logic                          m_degenerate,
    input wire logic                          m_last_sample
);

    // Hold a stalled result request
    `CBS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `CBS_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready,
        $stable(m_sample_index) && $stable(m_pos_x))
    // A zero derivative gives a zero normal
    `CBS_ASSERT_IMPLY(a_degen_zero, aclk, aresetn, m_valid && m_degenerate,
        m_norm_x == 16'sd0 && m_norm_y == 16'sd0 && m_norm_z == 16'sd0)
    // No new point is taken while a result that is not the last of its run is pending
    `CBS_ASSERT_IMPLY(a_busy_run, aclk, aresetn, m_valid && !m_last_sample, !s_ready)

endmodule

bind cubic_bezier_sampler cbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cbs_checker (.*);
`default_nettype wire
